// File: hw/rtl/wildcard_dna_pattern_matcher_macros.svh
// Assertion helpers used by the wdpm_reduce module.
// Each helper samples on the rising edge of clock and is disabled in reset.
`ifndef WILDCARD_DNA_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_DNA_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication.
`define WDPM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WDPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/wdpm_pkg.sv
package wdpm_pkg;

   // Sizing
   localparam int PATTERN_MAX   = 64;
   localparam int POSITION_BITS = 32;
   localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int GROUP_SIZE    = 8;
   localparam int GROUPS        = (PATTERN_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PADDED        = GROUPS * GROUP_SIZE;

   // Beat modes
   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_TEXT    = 2'd2;
   localparam logic [1:0] MODE_END     = 2'd3;

   // Symbol codes
   localparam logic [2:0] SYM_A     = 3'd0;
   localparam logic [2:0] SYM_C     = 3'd1;
   localparam logic [2:0] SYM_G     = 3'd2;
   localparam logic [2:0] SYM_T     = 3'd3;
   localparam logic [2:0] SYM_OTHER = 3'd4;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic [7:0] WILDCARD_RESET = 8'h3f;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] match_position;
      logic        pattern_truncated;
   } rsp_type;

   // Per-beat controls fanned out to every cell
   typedef struct packed {
      logic clear_pattern;
      logic clear_text;
      logic shift_pattern;
      logic shift_text;
   } cell_ctrl_type;

   // Side data that travels down the compare pipeline
   typedef struct packed {
      logic                     valid;
      logic                     fill_ok;
      logic                     truncated;
      logic [POSITION_BITS-1:0] start;
   } stage_type;

   function automatic logic [2:0] map_symbol(input logic [7:0] b);
      logic [2:0] s;
      case (b)
         CHAR_A:  s = SYM_A;
         CHAR_C:  s = SYM_C;
         CHAR_G:  s = SYM_G;
         CHAR_T:  s = SYM_T;
         default: s = SYM_OTHER;
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/wdpm_cell.sv
module wdpm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wdpm_pkg::cell_ctrl_type ctrl,
   input  logic                   load_match,
   input  logic [2:0]             sym_prev,
   input  logic                   care_prev,
   input  logic [2:0]             text_prev,
   output logic [2:0]             sym_out,
   output logic                   care_out,
   output logic [2:0]             text_out,
   output logic                   match
);
   import wdpm_pkg::*;

   logic [2:0] sym_ff, sym_in;
   logic       care_ff, care_in;
   logic [2:0] text_ff, text_in;
   logic       match_ff, match_in;

   // Advance the pattern and text chains
   always_comb begin
      sym_in  = ctrl.shift_pattern ? sym_prev : sym_ff;
      care_in = ctrl.clear_pattern ? 1'b0 : (ctrl.shift_pattern ? care_prev : care_ff);
      text_in = ctrl.clear_text ? SYM_A : (ctrl.shift_text ? text_prev : text_ff);
      // compare against the state this beat leaves behind
      match_in = !care_in || (sym_in == text_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         care_ff <= 1'b0;
         text_ff <= SYM_A;
      end else begin
         care_ff <= care_in;
         text_ff <= text_in;
      end
   end

   // Hold the symbol and the compare bit; no reset needed
   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      if (load_match) begin
         match_ff <= match_in;
      end
   end

   assign sym_out  = sym_ff;
   assign care_out = care_ff;
   assign text_out = text_ff;
   assign match    = match_ff;

endmodule

// File: hw/rtl/wdpm_reduce.sv
`include "wildcard_dna_pattern_matcher_macros.svh"

module wdpm_reduce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [wdpm_pkg::PATTERN_MAX-1:0]  cell_match,
   input  wdpm_pkg::stage_type               stage1,
   output logic                              ready_2,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wdpm_pkg::rsp_type                 rsp_data
);
   import wdpm_pkg::*;

   logic [PADDED-1:0] padded;
   logic [GROUPS-1:0] group_in, group_ff;
   stage_type         stage2_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              ready_3;

   assign ready_3 = !rsp_valid_ff || rsp_ready;
   assign ready_2 = !stage2_ff.valid || ready_3;

   // AND each group of cell compare bits; pad unused cells as matching
   always_comb begin
      padded                  = '1;
      padded[PATTERN_MAX-1:0] = cell_match;
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = &padded[g*GROUP_SIZE +: GROUP_SIZE];
      end
   end

   // Stage two: group results and side data
   always_ff @(posedge clock) begin
      if (reset) begin
         stage2_ff.valid <= 1'b0;
      end else if (ready_2) begin
         stage2_ff.valid <= stage1.valid;
      end
      if (ready_2) begin
         group_ff            <= group_in;
         stage2_ff.fill_ok   <= stage1.fill_ok;
         stage2_ff.truncated <= stage1.truncated;
         stage2_ff.start     <= stage1.start;
      end
   end

   // Stage three: final AND into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_3) begin
         rsp_valid_ff <= stage2_ff.valid && stage2_ff.fill_ok && (&group_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ready_3) begin
         rsp_ff.match_position    <= 32'(stage2_ff.start);
         rsp_ff.pattern_truncated <= stage2_ff.truncated;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `WDPM_ASSERT_NEXT(a_stage2_holds, stage2_ff.valid && !ready_3,
                     stage2_ff.valid && $stable(stage2_ff.start),
                     "stage two beat lost under stall")
   `WDPM_ASSERT_NEXT(a_short_window, stage2_ff.valid && ready_3 && !stage2_ff.fill_ok,
                     !rsp_valid_ff, "result for a window that does not fit")
   `WDPM_ASSERT_NEXT(a_no_invented, !stage2_ff.valid && ready_3, !rsp_valid_ff,
                     "result without a text beat")
   `WDPM_ASSERT_SAME(a_ready_when_empty, !stage2_ff.valid, ready_2,
                     "stage two refuses while empty")

endmodule

// File: hw/rtl/wildcard_dna_pattern_matcher.sv
// Wildcard DNA pattern matcher.
// Request channel (req_valid/req_ready/req_data) carries one beat per mode:
// clear, pattern byte, text byte or end of text. Pattern bytes equal to the
// wildcard byte (csr_write_enable/csr_write_data, reset '?') match any symbol.
// Result channel (rsp_valid/rsp_ready/rsp_data) gives the start position of
// every full text window that matches, in ascending order, with the current
// truncation flag. Clear, end-of-text and pattern beats produce no result.
// A text beat, once accepted, loads the cell compare bits, then the group
// AND register and then the result register, which presents its result.
// Throughput: one beat per cycle while req_ready is high, set by a row of 64
// cells that each compare one pattern symbol against one text symbol,
// followed by a two-stage registered AND tree.
// A stalled receiver first fills the pipeline bubbles; req_ready drops only
// once the result register and both compare stages are full.
// Reset (synchronous) empties the pattern and text, restores the wildcard
// byte and drops every beat in flight. No clearing pass is needed.
module wildcard_dna_pattern_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wdpm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wdpm_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);
   import wdpm_pkg::*;

   logic [7:0]               wildcard_ff;
   logic [LEN_BITS-1:0]      length_ff, length_in;
   logic [LEN_BITS-1:0]      fill_ff, fill_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic                     trunc_ff, trunc_in;
   stage_type                stage1_ff, stage1_in;
   logic                     ready_1, ready_2, accept;
   logic                     is_clear, is_pattern, is_text, is_end, room;
   cell_ctrl_type            ctrl;
   logic [2:0]               new_sym;
   logic                     new_care;

   logic [2:0]               sym_chain  [PATTERN_MAX+1];
   logic                     care_chain [PATTERN_MAX+1];
   logic [2:0]               text_chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0]   cell_match;

   assign ready_1   = !stage1_ff.valid || ready_2;
   assign req_ready = ready_1;
   assign accept    = req_valid && ready_1;

   // Decode the beat
   always_comb begin
      is_clear   = accept && (req_data.mode == MODE_CLEAR);
      is_pattern = accept && (req_data.mode == MODE_PATTERN);
      is_text    = accept && (req_data.mode == MODE_TEXT);
      is_end     = accept && (req_data.mode == MODE_END);
      room       = length_ff < LEN_BITS'(PATTERN_MAX);
      ctrl.clear_pattern = is_clear;
      ctrl.clear_text    = is_clear || is_end;
      ctrl.shift_pattern = is_pattern && room;
      ctrl.shift_text    = is_text;
      new_sym  = map_symbol(req_data.symbol_byte);
      new_care = req_data.symbol_byte != wildcard_ff;
   end

   // Update lengths, counts and the first compare stage
   always_comb begin
      length_in = length_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      trunc_in  = trunc_ff;
      if (is_clear) begin
         length_in = '0;
         fill_in   = '0;
         count_in  = '0;
         trunc_in  = 1'b0;
      end else if (is_end) begin
         fill_in  = '0;
         count_in = '0;
      end else if (is_pattern) begin
         if (room) begin
            length_in = length_ff + LEN_BITS'(1);
         end else begin
            trunc_in = 1'b1;
         end
      end else if (is_text) begin
         count_in = count_ff + POSITION_BITS'(1);
         if (fill_ff < LEN_BITS'(PATTERN_MAX)) begin
            fill_in = fill_ff + LEN_BITS'(1);
         end
      end
      stage1_in.valid     = is_text;
      stage1_in.fill_ok   = fill_in >= length_ff;
      stage1_in.truncated = trunc_ff;
      if (length_ff == '0) begin
         stage1_in.start = count_ff;
      end else begin
         stage1_in.start = count_ff + POSITION_BITS'(1)
                           - POSITION_BITS'(length_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wildcard_ff <= WILDCARD_RESET;
         length_ff   <= '0;
         fill_ff     <= '0;
         count_ff    <= '0;
         trunc_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            wildcard_ff <= csr_write_data;
         end
         length_ff <= length_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         trunc_ff  <= trunc_in;
      end
   end

   // Hold stage one side data alongside the cell compare bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff.valid <= 1'b0;
      end else if (ready_1) begin
         stage1_ff.valid <= stage1_in.valid;
      end
      if (ready_1) begin
         stage1_ff.fill_ok   <= stage1_in.fill_ok;
         stage1_ff.truncated <= stage1_in.truncated;
         stage1_ff.start     <= stage1_in.start;
      end
   end

   // Row of cells: new pattern and text symbols enter at cell zero
   assign sym_chain[0]  = new_sym;
   assign care_chain[0] = new_care;
   assign text_chain[0] = new_sym;

   for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_cell
      wdpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_match (ready_1),
         .sym_prev   (sym_chain[w]),
         .care_prev  (care_chain[w]),
         .text_prev  (text_chain[w]),
         .sym_out    (sym_chain[w+1]),
         .care_out   (care_chain[w+1]),
         .text_out   (text_chain[w+1]),
         .match      (cell_match[w])
      );
   end

   wdpm_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .cell_match (cell_match),
      .stage1     (stage1_ff),
      .ready_2    (ready_2),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
